FILE: hdl/sskk_pkg.sv
package sskk_pkg;

	localparam int VALUE_W      = 32;
	localparam int CFG_W        = 5;
	localparam int RANK_W       = 4;
	localparam int MAX_KEEP_DEF = 16;

	localparam logic [CFG_W-1:0] KEEP_COUNT_RESET = 5'd16;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_SHORT = 1'b1;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [CFG_W-1:0]          cfg_word_t;

	typedef struct packed {
		value_t sample_value;
		logic   is_final;
	} sample_t;

	typedef struct packed {
		value_t            kept_value;
		logic [RANK_W-1:0] rank;
		logic              end_of_run;
		logic              status;
	} result_t;

	// what a cell shows its right-hand neighbor
	typedef struct packed {
		logic   le;
		logic   valid;
		value_t value;
	} link_t;

endpackage

FILE: hdl/sskk_chan_if.sv
interface sskk_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/sskk_cell.sv
module sskk_cell #(
	parameter int IDX      = 0,
	parameter int MAX_KEEP = sskk_pkg::MAX_KEEP_DEF,
	parameter int KW       = $clog2(MAX_KEEP + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                is_final,
	input  sskk_pkg::value_t    sample,
	input  logic [KW-1:0]       keff,
	input  sskk_pkg::link_t     left,
	output sskk_pkg::link_t     right,
	output logic                valid_nx,
	input  logic                shift,
	input  sskk_pkg::value_t    drain_right,
	output sskk_pkg::value_t    drain
);
	import sskk_pkg::*;

	logic   valid_q;
	value_t value_q;
	value_t drain_q;
	value_t value_nx;
	logic   in_range;
	logic   eff_valid;
	logic   le;

	assign in_range  = KW'(IDX) < keff;
	assign eff_valid = valid_q & in_range;
	assign le        = eff_valid & (value_q <= sample);

	always_comb begin
		value_nx = value_q;
		valid_nx = eff_valid;
		if (!in_range) begin
			valid_nx = 1'b0;
		end else if (le) begin
			value_nx = value_q;
		end else if (left.le) begin
			// insertion point lands here
			value_nx = sample;
			valid_nx = 1'b1;
		end else begin
			value_nx = left.value;
			valid_nx = left.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= valid_nx & ~is_final;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			value_q <= value_nx;
		end
		if (take && is_final) begin
			drain_q <= value_nx;
		end else if (shift) begin
			drain_q <= drain_right;
		end
	end

	assign right = '{le: le, valid: eff_valid, value: value_q};
	assign drain = drain_q;

endmodule

FILE: hdl/streaming_smallest_k_keeper_core.sv
// Streaming smallest-k keeper.
// Channels: samples (sample_value, is_final), results (kept_value, rank,
// end_of_run, status) and cfg (keep_count write data), all valid/ready; a
// word moves on a rising edge with valid and ready both high.
// Each sample is compared against every kept cell at once and slots into a
// sorted chain of cells, one word per cycle, so non-final samples stream at full rate.
// On the final word the chain is copied into a drain row and cleared; the
// first result is valid the next cycle and results leave one per cycle while
// the receiver is ready: keff words in ascending order (keep_count, with zero
// read as one and values above MAX_KEEP capped), or one status word if the
// set was short. Non-final samples keep flowing while a run drains; a final
// sample waits until the previous run has fully left and enters the cycle
// after its last result is taken.
// A stalled receiver holds the current result; the drain row shifts only
// when a result is taken.
// Reset empties the chain, drops any run still draining and sets keep_count to 16.
// cfg is always ready; write it only while the block is idle.
module streaming_smallest_k_keeper_core #(
	parameter int MAX_KEEP = sskk_pkg::MAX_KEEP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sskk_chan_if.sink   samples,
	sskk_chan_if.source results,
	sskk_chan_if.sink   cfg
);
	import sskk_pkg::*;

	localparam int KW = $clog2(MAX_KEEP + 1);
	localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

	logic [CFG_W-1:0]  keep_count_q;
	logic [KW-1:0]     keff;
	logic [KW-1:0]     km1;
	logic              take;
	logic              take_final;
	logic              out_fire;
	logic              busy_q;
	logic              err_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     klast_q;
	logic              last_word;
	logic [IW+3:0]     rank_wide;

	link_t             link   [MAX_KEEP+1];
	value_t            drains [MAX_KEEP+1];
	logic [MAX_KEEP-1:0] valid_nx;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_COUNT_RESET;
		end else if (cfg.valid) begin
			keep_count_q <= cfg.data;
		end
	end

	always_comb begin
		if (keep_count_q == '0) begin
			keff = KW'(1);
		end else if (32'(keep_count_q) > MAX_KEEP) begin
			keff = KW'(MAX_KEEP);
		end else begin
			keff = KW'(keep_count_q);
		end
	end

	assign km1 = keff - KW'(1);

	// hold a final word back while the previous run still drains
	assign samples.ready = ~busy_q | ~samples.data.is_final;
	assign take          = samples.valid & samples.ready;
	assign take_final    = take & samples.data.is_final;
	assign out_fire      = results.valid & results.ready;
	assign last_word     = err_q | (idx_q == klast_q);

	assign link[0]          = '{le: 1'b1, valid: 1'b1, value: '0};
	assign drains[MAX_KEEP] = '0;

	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		sskk_cell #(
			.IDX      (i),
			.MAX_KEEP (MAX_KEEP),
			.KW       (KW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.take        (take),
			.is_final    (samples.data.is_final),
			.sample      (samples.data.sample_value),
			.keff        (keff),
			.left        (link[i]),
			.right       (link[i+1]),
			.valid_nx    (valid_nx[i]),
			.shift       (out_fire),
			.drain_right (drains[i+1]),
			.drain       (drains[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			err_q   <= 1'b0;
			idx_q   <= '0;
			klast_q <= '0;
		end else if (take_final) begin
			busy_q  <= 1'b1;
			err_q   <= ~valid_nx[km1[IW-1:0]];
			idx_q   <= '0;
			klast_q <= km1[IW-1:0];
		end else if (out_fire) begin
			if (last_word) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	assign rank_wide = {4'b0000, idx_q};

	assign results.valid           = busy_q;
	assign results.data.kept_value = err_q ? '0 : drains[0];
	assign results.data.rank       = err_q ? '0 : rank_wide[RANK_W-1:0];
	assign results.data.end_of_run = last_word;
	assign results.data.status     = err_q ? STATUS_SHORT : STATUS_OK;

	a_final_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		take_final |=> busy_q && idx_q == '0)
		else $error("final word did not start a run");

	a_no_final_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take && busy_q |-> !samples.data.is_final)
		else $error("final word taken while a run drains");

	a_rank_advances: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !last_word |=> busy_q && idx_q == $past(idx_q) + IW'(1))
		else $error("rank did not advance");

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= klast_q)
		else $error("rank beyond keep count");

endmodule

FILE: tb/sskk_checker.sv
`timescale 1ns / 100ps

module sskk_checker (
	input  logic  clk,
	input  logic  arst_n,
	sskk_chan_if  samples,
	sskk_chan_if  results,
	sskk_chan_if  cfg,
	output int    mismatches,
	output int    outstanding
);
	import sskk_pkg::*;

	cfg_word_t keep_shadow;
	value_t    kept_sorted [MAX_KEEP_DEF];
	int        kept_n;
	result_t   ranked_due [$];

	function automatic int active_keep(cfg_word_t r);
		if (r == '0)
			return 1;
		if (int'(r) > MAX_KEEP_DEF)
			return MAX_KEEP_DEF;
		return int'(r);
	endfunction

	task automatic insert_sample(sample_t s);
		int      k;
		int      p;
		int      top;
		result_t r;
		k = active_keep(keep_shadow);
		// trim the set if keep_count shrank since the last word
		if (kept_n > k)
			kept_n = k;
		p = 0;
		while (p < kept_n && kept_sorted[p] <= s.sample_value)
			p++;
		if (p < k) begin
			top = (kept_n < k) ? kept_n : k - 1;
			for (int i = top; i > p; i--)
				kept_sorted[i] = kept_sorted[i-1];
			kept_sorted[p] = s.sample_value;
			if (kept_n < k)
				kept_n++;
		end
		if (s.is_final) begin
			if (kept_n < k) begin
				r.kept_value = '0;
				r.rank       = '0;
				r.end_of_run = 1'b1;
				r.status     = STATUS_SHORT;
				ranked_due.push_back(r);
			end else begin
				for (int i = 0; i < k; i++) begin
					r.kept_value = kept_sorted[i];
					r.rank       = RANK_W'(i);
					r.end_of_run = (i == k - 1);
					r.status     = STATUS_OK;
					ranked_due.push_back(r);
				end
			end
			kept_n = 0;
		end
	endtask

	task automatic compare_result(result_t got);
		result_t want;
		bit      bad;
		if (ranked_due.size() == 0) begin
			$display("%0t: unexpected result word: value %0d rank %0d end %0b status %0b",
				$time, got.kept_value, got.rank, got.end_of_run, got.status);
			mismatches++;
			return;
		end
		want = ranked_due.pop_front();
		bad  = 1'b0;
		if (got.kept_value !== want.kept_value) begin
			$display("%0t: kept_value expected %0d, got %0d",
				$time, want.kept_value, got.kept_value);
			bad = 1'b1;
		end
		if (got.rank !== want.rank) begin
			$display("%0t: rank expected %0d, got %0d", $time, want.rank, got.rank);
			bad = 1'b1;
		end
		if (got.end_of_run !== want.end_of_run) begin
			$display("%0t: end_of_run expected %0b, got %0b",
				$time, want.end_of_run, got.end_of_run);
			bad = 1'b1;
		end
		if (got.status !== want.status) begin
			$display("%0t: status expected %0b, got %0b", $time, want.status, got.status);
			bad = 1'b1;
		end
		if (bad)
			mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_shadow = KEEP_COUNT_RESET;
			kept_n      = 0;
			ranked_due.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				keep_shadow = cfg.data;
			if (samples.valid && samples.ready)
				insert_sample(samples.data);
			if (results.valid && results.ready)
				compare_result(results.data);
			outstanding = ranked_due.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import sskk_pkg::*;

	localparam int SETTLE_CYCLES   = 20;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int STALL_LIMIT     = 2000;
	localparam int WORDS_PER_SETTING = 18;

	logic clk = 1'b0;
	logic arst_n;

	int   src_idle_pct;
	int   sink_idle_pct;
	logic hold_off_req;
	int   chk_errors;
	int   chk_pending;

	sskk_chan_if #(.T(sample_t))   samples_ch ();
	sskk_chan_if #(.T(result_t))   results_ch ();
	sskk_chan_if #(.T(cfg_word_t)) cfg_ch ();

	always #5 clk = ~clk;

	streaming_smallest_k_keeper_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	sskk_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples_ch),
		.results     (results_ch),
		.cfg         (cfg_ch),
		.mismatches  (chk_errors),
		.outstanding (chk_pending)
	);

	function automatic int keep_in_use(cfg_word_t r);
		if (r == '0)
			return 1;
		return (int'(r) > MAX_KEEP_DEF) ? MAX_KEEP_DEF : int'(r);
	endfunction

	function automatic value_t pick_value();
		int t;
		case ($urandom_range(9))
			0: return {1'b1, {(VALUE_W-1){1'b0}}};
			1: return {1'b0, {(VALUE_W-1){1'b1}}};
			2, 3: begin
				// narrow range: makes ties with kept values likely
				t = $urandom_range(16);
				return value_t'(t - 8);
			end
			default: return value_t'($urandom);
		endcase
	endfunction

	task automatic send_sample(value_t v, logic fin);
		sample_t s;
		s.sample_value = v;
		s.is_final     = fin;
		if ($urandom_range(99) < src_idle_pct) begin
			samples_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.data  <= s;
		do @(posedge clk); while (!samples_ch.ready);
	endtask

	// drop valid, let every expected word come out, then let the block settle
	task automatic wait_idle();
		samples_ch.valid <= 1'b0;
		do @(posedge clk); while (chk_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_keep(cfg_word_t v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_set(int size);
		for (int i = 0; i < size; i++)
			send_sample(pick_value(), i == size - 1);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		results_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				results_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				results_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
				@(posedge clk);
			end
		end
	end

	initial begin
		int stalled;
		stalled = 0;
		wait (arst_n === 1'b1);
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((samples_ch.valid && samples_ch.ready) ||
			    (results_ch.valid && results_ch.ready) ||
			    (cfg_ch.valid && cfg_ch.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		cfg_word_t plan [9];
		int        kk;
		int        words;
		int        size;
		plan = '{5'd31, 5'd1, 5'd7, 5'd0, 5'd16, 5'd12, 5'd2, 5'd20, 5'd5};
		arst_n           = 1'b0;
		hold_off_req     = 1'b0;
		src_idle_pct     = 11;
		sink_idle_pct    = 84;
		samples_ch.valid = 1'b0;
		samples_ch.data  = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.data      = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset keep_count of 16, short set
		send_sample({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
		send_sample({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
		send_sample(-1, 1'b1);
		wait_idle();

		// zero acts as one
		write_keep(5'd0);
		send_sample(0, 1'b0);
		send_sample({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
		send_sample({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
		send_sample(1, 1'b1);
		wait_idle();

		// ties with the largest kept value, alternating bit patterns
		write_keep(5'd4);
		send_sample(5, 1'b0);
		send_sample(32'h5555_5555, 1'b0);
		send_sample(5, 1'b0);
		send_sample(-3, 1'b0);
		send_sample(32'hAAAA_AAAA, 1'b0);
		send_sample(5, 1'b1);
		wait_idle();

		// lower keep_count in the middle of a set
		write_keep(5'd16);
		send_sample(9, 1'b0);
		send_sample(-9, 1'b0);
		send_sample(100, 1'b0);
		send_sample(0, 1'b0);
		send_sample(-100, 1'b0);
		send_sample(7, 1'b0);
		wait_idle();
		write_keep(5'd2);
		send_sample(8, 1'b1);
		wait_idle();

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct  = (ph == 0) ? 11 : (ph == 1) ? 84 : 0;
			sink_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 11 : 0;
			for (int c = 0; c < 3; c++) begin
				write_keep(plan[ph*3 + c]);
				kk = keep_in_use(plan[ph*3 + c]);
				// hold the receiver so the drain row fills and input stalls
				if (ph == 2 && c == 0)
					hold_off_req = 1'b1;
				words = 0;
				while (words < WORDS_PER_SETTING) begin
					case ($urandom_range(9))
						0, 1: size = (kk > 1) ? $urandom_range(1, kk - 1) : 1;
						9: size = kk + $urandom_range(7, 20);
						default: size = kk + $urandom_range(0, 6);
					endcase
					send_set(size);
					words += size;
				end
				wait_idle();
			end
		end

		if (chk_errors == 0 && chk_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: streaming_smallest_k_keeper_core.f
hdl/sskk_pkg.sv
hdl/sskk_chan_if.sv
hdl/sskk_cell.sv
hdl/streaming_smallest_k_keeper_core.sv
tb/sskk_checker.sv
tb/tb_top.sv
